[hdl/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared widths, codes and the cell update command of the lru key-value cache
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int KEY_W       = 16;
	localparam int VALUE_W     = 31;
	localparam int CAP_W       = 5;
	localparam int DEF_ENTRIES = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef struct packed {
		logic               upd;
		logic               wr;
		logic               age_all;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} lkvc_cmd_t;

endpackage

[hdl/lkvc_cell.sv]
// ----------------------------------------------------------------------------
// lkvc_cell
// one cache entry: key, value, valid and recency rank, with search chain links
// ----------------------------------------------------------------------------
module lkvc_cell
	import lkvc_pkg::*;
#(
	parameter int RANK_W = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lkvc_cmd_t          cmd,
	input  logic               sel,
	input  logic [RANK_W-1:0]  thr,
	input  logic [KEY_W-1:0]   look_key,
	input  logic [RANK_W-1:0]  old_rank,
	input  logic               free_in,
	input  logic               hit_in,
	input  logic [VALUE_W-1:0] hval_in,
	input  logic [RANK_W-1:0]  hrank_in,
	output logic               free_out,
	output logic               hit_out,
	output logic [VALUE_W-1:0] hval_out,
	output logic [RANK_W-1:0]  hrank_out,
	output logic               hit,
	output logic               free_claim,
	output logic               old
);

	logic               valid_q;
	logic [RANK_W-1:0]  rank_q;
	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (cmd.upd) begin
			if (sel) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
			end else if (valid_q && (cmd.age_all || rank_q < thr)) begin
				rank_q <= rank_q + RANK_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd && sel && cmd.wr) begin
			key_q   <= cmd.key;
			value_q <= cmd.value;
		end
	end

	assign hit        = valid_q && (key_q == look_key);
	assign free_claim = !valid_q && !free_in;
	assign free_out   = free_in || !valid_q;
	assign old        = valid_q && (rank_q == old_rank);
	assign hit_out    = hit_in || hit;
	assign hval_out   = hval_in | (hit ? value_q : '0);
	assign hrank_out  = hrank_in | (hit ? rank_q : '0);

endmodule

[hdl/lru_key_value_cache_top.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// fully associative key-value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// requests enter on the s_ channel: s_tuser is the op (0 get, 1 put), s_tdata
// carries key and value. a get returns one result on the m_ channel: m_tuser
// is the hit flag, m_tdata the stored value (zero on a miss). a put returns
// nothing. cfg_we / cfg_wdata set the capacity in use (0 acts as 1, values
// above ENTRIES act as ENTRIES); write it only while the cache is idle.
// each request passes a lookup state, where every cell compares its key
// and the free / hit chains run through the row, and then an update
// state, where the cells move ranks and write the selected entry. a new
// request is taken in the update cycle of the previous one, so a request
// can enter while the last one finishes, but none during lookup; a get
// result is loaded into the output register as its update completes. when
// m_tready is low and a result is still held, the next get waits in its
// update cycle and s_tready is low. reset empties the cache at once (valid
// bits cleared) and sets the capacity to 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top
	import lkvc_pkg::*;
#(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [47:0]      s_tdata,   // key [15:0], value [46:16], zero [47]
	input  logic [0:0]       s_tuser,   // op [0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [31:0]      m_tdata,   // found_value [30:0], zero [31]
	output logic [0:0]       m_tuser,   // hit [0]
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata
);

	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W  = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0]         state_q;
	logic               op_q;
	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] value_q;
	logic [CAP_W-1:0]   cap_q;
	logic [OCC_W-1:0]   occ_q;

	logic [ENTRIES-1:0] sel_q;
	logic [RANK_W-1:0]  thr_q;
	logic               age_all_q;
	logic               wr_q;
	logic               ins_q;
	logic               hit_q;
	logic [VALUE_W-1:0] fval_q;

	logic               m_tvalid_q;
	logic               m_hit_q;
	logic [VALUE_W-1:0] m_val_q;

	logic [ENTRIES-1:0] hit_vec;
	logic [ENTRIES-1:0] free_vec;
	logic [ENTRIES-1:0] old_vec;
	logic               free_ch  [ENTRIES+1];
	logic               hit_ch   [ENTRIES+1];
	logic [VALUE_W-1:0] hval_ch  [ENTRIES+1];
	logic [RANK_W-1:0]  hrank_ch [ENTRIES+1];

	lkvc_cmd_t          cmd;
	logic               accept;
	logic               can_finish;
	logic               upd_en;
	logic               full;
	logic [OCC_W-1:0]   occ_m1;
	logic [CMP_W-1:0]   cap_eff;

	assign can_finish = (op_q == OP_PUT) || !m_tvalid_q || m_tready;
	assign upd_en     = (state_q == ST_UPD) && can_finish;
	assign s_tready   = (state_q == ST_IDLE) || upd_en;
	assign accept     = s_tvalid && s_tready;

	assign cmd.upd     = upd_en;
	assign cmd.wr      = wr_q;
	assign cmd.age_all = age_all_q;
	assign cmd.key     = key_q;
	assign cmd.value   = value_q;

	assign free_ch[0]  = 1'b0;
	assign hit_ch[0]   = 1'b0;
	assign hval_ch[0]  = '0;
	assign hrank_ch[0] = '0;

	assign occ_m1 = occ_q - OCC_W'(1);

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lkvc_cell #(
			.RANK_W(RANK_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.sel       (sel_q[i]),
			.thr       (thr_q),
			.look_key  (key_q),
			.old_rank  (occ_m1[RANK_W-1:0]),
			.free_in   (free_ch[i]),
			.hit_in    (hit_ch[i]),
			.hval_in   (hval_ch[i]),
			.hrank_in  (hrank_ch[i]),
			.free_out  (free_ch[i+1]),
			.hit_out   (hit_ch[i+1]),
			.hval_out  (hval_ch[i+1]),
			.hrank_out (hrank_ch[i+1]),
			.hit       (hit_vec[i]),
			.free_claim(free_vec[i]),
			.old       (old_vec[i])
		);
	end

	// saturate capacity to 1 .. ENTRIES
	always_comb begin
		cap_eff = (cap_q == '0) ? CMP_W'(1) : CMP_W'(cap_q);
		if (cap_eff > CMP_W'(ENTRIES)) begin
			cap_eff = CMP_W'(ENTRIES);
		end
		full = (CMP_W'(occ_q) >= cap_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cap_q   <= CAP_RESET;
			occ_q   <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (upd_en) begin
						state_q <= accept ? ST_LOOK : ST_IDLE;
						if (ins_q) begin
							occ_q <= occ_q + OCC_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= s_tuser[0];
			key_q   <= s_tdata[KEY_W-1:0];
			value_q <= s_tdata[KEY_W+VALUE_W-1:KEY_W];
		end
	end

	// lookup results, registered for the update cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q     <= '0;
			thr_q     <= '0;
			age_all_q <= 1'b0;
			wr_q      <= 1'b0;
			ins_q     <= 1'b0;
			hit_q     <= 1'b0;
			fval_q    <= '0;
		end else if (state_q == ST_LOOK) begin
			hit_q     <= hit_ch[ENTRIES];
			fval_q    <= hval_ch[ENTRIES];
			thr_q     <= hrank_ch[ENTRIES];
			age_all_q <= 1'b0;
			ins_q     <= 1'b0;
			wr_q      <= (op_q == OP_PUT);
			sel_q     <= hit_ch[ENTRIES] ? hit_vec : '0;
			if (op_q == OP_PUT && !hit_ch[ENTRIES]) begin
				if (full) begin
					sel_q <= old_vec;
					thr_q <= occ_m1[RANK_W-1:0];
				end else begin
					sel_q     <= free_vec;
					age_all_q <= 1'b1;
					ins_q     <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (upd_en && op_q == OP_GET) begin
				m_tvalid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_en && op_q == OP_GET) begin
			m_hit_q <= hit_q;
			m_val_q <= fval_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_hit_q;
	assign m_tdata  = {1'b0, m_val_q};

	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |-> $onehot0(hit_vec))
		else $error("more than one entry matches the key");

	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> $onehot0(sel_q))
		else $error("update selects more than one entry");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(ENTRIES))
		else $error("occupancy above entry count");

	a_no_take_in_look: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |-> !s_tready)
		else $error("request taken during lookup");

	a_result_from_upd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_UPD && op_q == OP_GET))
		else $error("result without a finished get");

endmodule
